FILE: hw/rtl/decimal_accumulator_machine_defines.svh
// ----------------------------------------------------------------------------
// Decimal accumulator machine: assertion macros
// Shared property shorthands, sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_ACCUMULATOR_MACHINE_DEFINES_SVH
`define DECIMAL_ACCUMULATOR_MACHINE_DEFINES_SVH

// Same-cycle implication
`define DAM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define DAM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/dam_pkg.sv
// ----------------------------------------------------------------------------
// Decimal accumulator machine package
// Word format, command, status and opcode codes, divider interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package dam_pkg;

  // Machine geometry
  localparam int MEM_WORDS = 100;
  localparam int ADDR_W    = $clog2(MEM_WORDS);
  localparam int WORD_W    = 15;
  localparam int MAG_W     = WORD_W - 1;
  localparam logic signed [WORD_W-1:0] WORD_MAX = 15'sd9999;

  // Decode of word / 100 by reciprocal multiply: q = (|w| * 5243) >> 19
  localparam int DEC_BASE    = 100;
  localparam int RECIP       = 5243;
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 19;
  localparam int DIGIT_W     = 7;

  // Divider geometry
  localparam int DIV_BITS  = MAG_W;
  localparam int DIV_CNT_W = $clog2(DIV_BITS);

  // Commands
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_STEP  = 2'd2;

  // Status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_HALT    = 3'd1;
  localparam logic [2:0] ST_OVF     = 3'd2;
  localparam logic [2:0] ST_DIVZ    = 3'd3;
  localparam logic [2:0] ST_PAST    = 3'd4;
  localparam logic [2:0] ST_FULL    = 3'd5;
  localparam logic [2:0] ST_IGNORED = 3'd6;

  // Opcodes
  localparam logic signed [7:0] OP_READ  = 8'sd10;
  localparam logic signed [7:0] OP_WRITE = 8'sd11;
  localparam logic signed [7:0] OP_LOAD  = 8'sd20;
  localparam logic signed [7:0] OP_STORE = 8'sd21;
  localparam logic signed [7:0] OP_ADD   = 8'sd30;
  localparam logic signed [7:0] OP_SUB   = 8'sd31;
  localparam logic signed [7:0] OP_DIV   = 8'sd32;
  localparam logic signed [7:0] OP_MUL   = 8'sd33;
  localparam logic signed [7:0] OP_BR    = 8'sd40;
  localparam logic signed [7:0] OP_BRNEG = 8'sd41;
  localparam logic signed [7:0] OP_BRZERO = 8'sd42;
  localparam logic signed [7:0] OP_HALT  = 8'sd43;

  // Divider request and response
  typedef struct packed {
    logic                     start;
    logic signed [WORD_W-1:0] dividend;
    logic signed [WORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [WORD_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dam_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module dam_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 100
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/dam_div.sv
// ----------------------------------------------------------------------------
// Iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
`default_nettype none

module dam_div
  import dam_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [MAG_W-1:0]     rem_r, rem_nxt;
  logic [MAG_W-1:0]     quo_r, quo_nxt;
  logic [MAG_W-1:0]     dvs_r, dvs_nxt;
  logic                 neg_r, neg_nxt;

  logic [WORD_W-1:0]    dvd_abs;
  logic [WORD_W-1:0]    dvs_abs;
  logic [MAG_W:0]       rem_sh;
  logic                 fits;
  logic [MAG_W:0]       rem_sub;

  // Operand magnitudes
  assign dvd_abs = req.dividend[WORD_W-1] ? WORD_W'(-req.dividend) : req.dividend;
  assign dvs_abs = req.divisor[WORD_W-1]  ? WORD_W'(-req.divisor)  : req.divisor;

  // Trial subtract of one step
  assign rem_sh  = {rem_r, quo_r[MAG_W-1]};
  assign fits    = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dvd_abs[MAG_W-1:0];
      dvs_nxt  = dvs_abs[MAG_W-1:0];
      neg_nxt  = req.dividend[WORD_W-1] ^ req.divisor[WORD_W-1];
    end else if (busy_r) begin
      rem_nxt = fits ? rem_sub[MAG_W-1:0] : rem_sh[MAG_W-1:0];
      quo_nxt = {quo_r[MAG_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});

endmodule

`default_nettype wire

FILE: hw/rtl/decimal_accumulator_machine.sv
// ----------------------------------------------------------------------------
// Decimal accumulator machine
// Hundred-word, four-digit signed accumulator computer with command port.
// ----------------------------------------------------------------------------
// Usage:
//   An item (in_cmd, in_data) is taken at a clock edge with start high and
//   busy low. Clear, load, an ignored step and an unused command finish at
//   once: the result strobe out_valid rises on the next cycle and busy stays
//   low, so one such item per cycle is possible.
//   A step command raises busy while the sequencer fetches the word, decodes
//   it with a reciprocal multiply, reads the operand and executes: busy falls
//   with the result strobe, and a new item can be taken at the edge that ends
//   the result cycle. A divide runs the iterative divider, one quotient bit
//   per cycle, and its result strobe comes once the quotient is done.
//   Each result is shown for exactly one cycle with out_valid high; the
//   receiver must take it then, it cannot hold results off.
//   Reset (and the clear command) empties the 100-word memory at once by
//   clearing its per-word valid bits; an invalid word reads as zero. No
//   clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "decimal_accumulator_machine_defines.svh"

module decimal_accumulator_machine
  import dam_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [1:0]               in_cmd,
  input  wire logic signed [WORD_W-1:0] in_data,
  output logic                          out_valid,
  output logic [2:0]                    out_status,
  output logic                          out_write_valid,
  output logic signed [WORD_W-1:0]      out_write_value,
  output logic                          out_read_taken,
  output logic [ADDR_W-1:0]             out_program_counter,
  output logic signed [WORD_W-1:0]      out_acc_value,
  output logic signed [WORD_W-1:0]      out_instruction_word,
  output logic signed [7:0]             out_opcode,
  output logic signed [7:0]             out_address_field
);

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FETCH  = 3'd1;
  localparam logic [2:0] S_DECODE = 3'd2;
  localparam logic [2:0] S_OPER   = 3'd3;
  localparam logic [2:0] S_EXEC   = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;

  localparam int PROD_W = MAG_W + RECIP_W;

  // Architectural state
  logic [2:0]               st_r, st_nxt;
  logic [ADDR_W-1:0]        lp_r, lp_nxt;
  logic [ADDR_W-1:0]        ic_r, ic_nxt;
  logic signed [WORD_W-1:0] acc_r, acc_nxt;
  logic                     stopped_r, stopped_nxt;
  logic [MEM_WORDS-1:0]     valid_r, valid_nxt;
  logic                     vld_rd_r, vld_rd_nxt;

  // Instruction in flight
  logic signed [WORD_W-1:0] data_r, data_nxt;
  logic signed [WORD_W-1:0] word_r, word_nxt;
  logic [DIGIT_W-1:0]       qmag_r, qmag_nxt;
  logic signed [7:0]        op_r, op_nxt;
  logic signed [7:0]        addr_r, addr_nxt;

  // Result registers
  logic                     out_valid_r, out_valid_nxt;
  logic [2:0]               out_status_r, out_status_nxt;
  logic                     out_wvalid_r, out_wvalid_nxt;
  logic signed [WORD_W-1:0] out_wvalue_r, out_wvalue_nxt;
  logic                     out_rtaken_r, out_rtaken_nxt;
  logic [ADDR_W-1:0]        out_pc_r, out_pc_nxt;
  logic signed [WORD_W-1:0] out_acc_r, out_acc_nxt;
  logic signed [WORD_W-1:0] out_word_r, out_word_nxt;
  logic signed [7:0]        out_op_r, out_op_nxt;
  logic signed [7:0]        out_addr_r, out_addr_nxt;

  // Memory port
  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  logic [WORD_W-1:0]        ram_wdata;
  logic [ADDR_W-1:0]        ram_raddr;
  logic [WORD_W-1:0]        ram_rdata;

  // Datapath
  logic signed [WORD_W-1:0] m_val;
  logic [WORD_W-1:0]        word_abs;
  logic [MAG_W-1:0]         wmag;
  logic [PROD_W-1:0]        dec_prod;
  logic [MAG_W-1:0]         rem_full;
  logic [ADDR_W-1:0]        op_addr;
  logic signed [WORD_W:0]   add_res;
  logic signed [WORD_W:0]   sub_res;
  logic signed [2*WORD_W-1:0] mul_res;
  logic signed [WORD_W-1:0] data_sat;
  logic                     load_ok;

  // Finish of a step
  logic                     do_fin;
  logic [2:0]               fin_status;
  logic [ADDR_W-1:0]        fin_next;
  logic                     e_wvalid;
  logic signed [WORD_W-1:0] e_wvalue;
  logic                     e_rtaken;

  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  dam_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MEM_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dam_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Operand read: a never-written word reads as zero
  assign m_val = vld_rd_r ? $signed(ram_rdata) : '0;

  // Decode of word / 100 and word % 100 on the magnitude
  assign word_abs = word_r[WORD_W-1] ? WORD_W'(-word_r) : word_r;
  assign wmag     = word_abs[MAG_W-1:0];
  assign dec_prod = PROD_W'(wmag) * PROD_W'(RECIP);
  assign rem_full = wmag - MAG_W'(qmag_r) * MAG_W'(DEC_BASE);
  assign op_addr  = addr_r[7] ? '0 : addr_r[ADDR_W-1:0];

  // Arithmetic unit
  assign add_res = acc_r + m_val;
  assign sub_res = acc_r - m_val;
  assign mul_res = acc_r * m_val;

  // Read value and load range checks
  assign data_sat = (data_r > WORD_MAX) ? WORD_MAX :
                    (data_r < -WORD_MAX) ? -WORD_MAX : data_r;
  assign load_ok  = (in_data <= WORD_MAX) && (in_data >= -WORD_MAX);

  assign busy = (st_r != S_IDLE);

  // Sequencer and next state
  always_comb begin
    st_nxt      = st_r;
    lp_nxt      = lp_r;
    ic_nxt      = ic_r;
    acc_nxt     = acc_r;
    stopped_nxt = stopped_r;
    valid_nxt   = valid_r;
    data_nxt    = data_r;
    word_nxt    = word_r;
    qmag_nxt    = qmag_r;
    op_nxt      = op_r;
    addr_nxt    = addr_r;

    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_wvalid_nxt = out_wvalid_r;
    out_wvalue_nxt = out_wvalue_r;
    out_rtaken_nxt = out_rtaken_r;
    out_pc_nxt     = out_pc_r;
    out_acc_nxt    = out_acc_r;
    out_word_nxt   = out_word_r;
    out_op_nxt     = out_op_r;
    out_addr_nxt   = out_addr_r;

    ram_we    = 1'b0;
    ram_waddr = lp_r;
    ram_wdata = in_data;
    ram_raddr = '0;

    div_req.start    = 1'b0;
    div_req.dividend = m_val;
    div_req.divisor  = acc_r;

    do_fin     = 1'b0;
    fin_status = ST_OK;
    fin_next   = ic_r + 1'b1;
    e_wvalid   = 1'b0;
    e_wvalue   = '0;
    e_rtaken   = 1'b0;

    case (st_r)
      S_IDLE: begin
        if (start) begin
          // Commands that finish at once report with empty step fields
          out_status_nxt = ST_OK;
          out_wvalid_nxt = 1'b0;
          out_wvalue_nxt = '0;
          out_rtaken_nxt = 1'b0;
          out_word_nxt   = '0;
          out_op_nxt     = '0;
          out_addr_nxt   = '0;
          case (in_cmd)
            CMD_CLEAR: begin
              lp_nxt        = '0;
              ic_nxt        = '0;
              acc_nxt       = '0;
              stopped_nxt   = 1'b0;
              valid_nxt     = '0;
              out_valid_nxt = 1'b1;
            end
            CMD_LOAD: begin
              out_valid_nxt = 1'b1;
              if (lp_r >= ADDR_W'(MEM_WORDS)) begin
                out_status_nxt = ST_FULL;
              end else if (load_ok) begin
                ram_we            = 1'b1;
                valid_nxt[lp_r]   = 1'b1;
                lp_nxt            = lp_r + 1'b1;
                if (lp_r == ADDR_W'(MEM_WORDS - 1)) begin
                  out_status_nxt = ST_FULL;
                end
              end
            end
            CMD_STEP: begin
              if (stopped_r || (ic_r >= ADDR_W'(MEM_WORDS))) begin
                out_status_nxt = ST_IGNORED;
                out_valid_nxt  = 1'b1;
              end else begin
                ram_raddr = ic_r;
                data_nxt  = in_data;
                st_nxt    = S_FETCH;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      // Instruction word arrives from memory
      S_FETCH: begin
        word_nxt = m_val;
        st_nxt   = S_DECODE;
      end

      // Quotient digit pair by reciprocal multiply
      S_DECODE: begin
        qmag_nxt = dec_prod[RECIP_SHIFT +: DIGIT_W];
        st_nxt   = S_OPER;
      end

      // Signed opcode and address; start the operand read
      S_OPER: begin
        op_nxt   = word_r[WORD_W-1] ? -$signed({1'b0, qmag_r}) : $signed({1'b0, qmag_r});
        addr_nxt = word_r[WORD_W-1] ? -$signed({1'b0, rem_full[DIGIT_W-1:0]})
                                    : $signed({1'b0, rem_full[DIGIT_W-1:0]});
        ram_raddr = word_r[WORD_W-1] ? '0 : rem_full[ADDR_W-1:0];
        st_nxt    = S_EXEC;
      end

      // Execute with the operand word
      S_EXEC: begin
        do_fin = 1'b1;
        case (op_r)
          OP_READ: begin
            ram_we           = 1'b1;
            ram_waddr        = op_addr;
            ram_wdata        = data_sat;
            valid_nxt[op_addr] = 1'b1;
            e_rtaken         = 1'b1;
          end
          OP_WRITE: begin
            e_wvalid = 1'b1;
            e_wvalue = m_val;
          end
          OP_LOAD: begin
            acc_nxt = m_val;
          end
          OP_STORE: begin
            ram_we             = 1'b1;
            ram_waddr          = op_addr;
            ram_wdata          = acc_r;
            valid_nxt[op_addr] = 1'b1;
          end
          OP_ADD: begin
            if ((add_res > WORD_MAX) || (add_res < -WORD_MAX)) begin
              fin_status = ST_OVF;
              fin_next   = ic_r;
            end else begin
              acc_nxt = add_res[WORD_W-1:0];
            end
          end
          OP_SUB: begin
            if ((sub_res > WORD_MAX) || (sub_res < -WORD_MAX)) begin
              fin_status = ST_OVF;
              fin_next   = ic_r;
            end else begin
              acc_nxt = sub_res[WORD_W-1:0];
            end
          end
          OP_MUL: begin
            if ((mul_res > WORD_MAX) || (mul_res < -WORD_MAX)) begin
              fin_status = ST_OVF;
              fin_next   = ic_r;
            end else begin
              acc_nxt = mul_res[WORD_W-1:0];
            end
          end
          OP_DIV: begin
            if (acc_r == '0) begin
              fin_status = ST_DIVZ;
              fin_next   = ic_r;
            end else begin
              div_req.start = 1'b1;
              do_fin        = 1'b0;
              st_nxt        = S_DIV;
            end
          end
          OP_BR: begin
            fin_next = op_addr;
          end
          OP_BRNEG: begin
            if (acc_r < 0) begin
              fin_next = op_addr;
            end
          end
          OP_BRZERO: begin
            if (acc_r == '0) begin
              fin_next = op_addr;
            end
          end
          OP_HALT: begin
            fin_status = ST_HALT;
            fin_next   = ic_r;
          end
          default: begin
          end
        endcase
      end

      // Wait for the quotient
      S_DIV: begin
        if (div_rsp.done) begin
          acc_nxt = div_rsp.quotient;
          do_fin  = 1'b1;
        end
      end

      default: begin
        st_nxt = S_IDLE;
      end
    endcase

    // Common end of a step: counter, stop flag and result
    if (do_fin) begin
      st_nxt         = S_IDLE;
      ic_nxt         = fin_next;
      out_status_nxt = fin_status;
      if (fin_status != ST_OK) begin
        stopped_nxt = 1'b1;
      end else if (fin_next >= ADDR_W'(MEM_WORDS)) begin
        ic_nxt         = ADDR_W'(MEM_WORDS);
        out_status_nxt = ST_PAST;
        stopped_nxt    = 1'b1;
      end
      out_valid_nxt  = 1'b1;
      out_wvalid_nxt = e_wvalid;
      out_wvalue_nxt = e_wvalue;
      out_rtaken_nxt = e_rtaken;
      out_word_nxt   = word_r;
      out_op_nxt     = op_r;
      out_addr_nxt   = addr_r;
    end

    // Counter and accumulator as left by this item
    if (out_valid_nxt) begin
      out_pc_nxt  = ic_nxt;
      out_acc_nxt = acc_nxt;
    end

    vld_rd_nxt = valid_r[ram_raddr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      lp_r        <= '0;
      ic_r        <= '0;
      acc_r       <= '0;
      stopped_r   <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      lp_r        <= lp_nxt;
      ic_r        <= ic_nxt;
      acc_r       <= acc_nxt;
      stopped_r   <= stopped_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    vld_rd_r     <= vld_rd_nxt;
    data_r       <= data_nxt;
    word_r       <= word_nxt;
    qmag_r       <= qmag_nxt;
    op_r         <= op_nxt;
    addr_r       <= addr_nxt;
    out_status_r <= out_status_nxt;
    out_wvalid_r <= out_wvalid_nxt;
    out_wvalue_r <= out_wvalue_nxt;
    out_rtaken_r <= out_rtaken_nxt;
    out_pc_r     <= out_pc_nxt;
    out_acc_r    <= out_acc_nxt;
    out_word_r   <= out_word_nxt;
    out_op_r     <= out_op_nxt;
    out_addr_r   <= out_addr_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_write_valid      = out_wvalid_r;
  assign out_write_value      = out_wvalue_r;
  assign out_read_taken       = out_rtaken_r;
  assign out_program_counter  = out_pc_r;
  assign out_acc_value        = out_acc_r;
  assign out_instruction_word = out_word_r;
  assign out_opcode           = out_op_r;
  assign out_address_field    = out_addr_r;

  // Checks
  `DAM_ASSERT_NEXT(a_busy_end_reports,
                   (st_r != S_IDLE) && (st_nxt == S_IDLE),
                   out_valid, "step finished without a result")
  `DAM_ASSERT_NEXT(a_stopped_ignores,
                   !busy && start && (in_cmd == CMD_STEP) && stopped_r,
                   out_valid && (out_status == ST_IGNORED),
                   "step on stopped machine not ignored")
  `DAM_ASSERT_NOW(a_div_done_in_div, div_rsp.done, st_r == S_DIV,
                  "quotient arrived outside divide")
  `DAM_ASSERT_NOW(a_pc_range, out_valid, out_program_counter <= ADDR_W'(MEM_WORDS),
                  "counter beyond end of memory")

endmodule

`default_nettype wire

FILE: tb/dam_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Decimal accumulator machine: result checker
// Keeps its own copy of the machine state and updates it from each accepted
// item. It predicts every result and compares the strobed fields in order.
// ----------------------------------------------------------------------------
module dam_result_checker
  import dam_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     busy,
  input  logic [1:0]               in_cmd,
  input  logic signed [WORD_W-1:0] in_data,
  input  logic                     out_valid,
  input  logic [2:0]               out_status,
  input  logic                     out_write_valid,
  input  logic signed [WORD_W-1:0] out_write_value,
  input  logic                     out_read_taken,
  input  logic [ADDR_W-1:0]        out_program_counter,
  input  logic signed [WORD_W-1:0] out_acc_value,
  input  logic signed [WORD_W-1:0] out_instruction_word,
  input  logic signed [7:0]        out_opcode,
  input  logic signed [7:0]        out_address_field,
  output int                       fault_count,
  output int                       awaiting,
  output int                       result_count,
  output int                       ignored_count,
  output int                       stop_count
);

  localparam int WORD_LIMIT   = 9999;
  localparam int REPORT_LIMIT = 10;

  typedef struct {
    logic [2:0]               status;
    logic                     wr_valid;
    logic signed [WORD_W-1:0] wr_value;
    logic                     rd_taken;
    logic [ADDR_W-1:0]        pc;
    logic signed [WORD_W-1:0] acc;
    logic signed [WORD_W-1:0] word;
    logic signed [7:0]        op;
    logic signed [7:0]        addr;
  } machine_report_t;

  // Mirror of the machine
  int mem_mirror [MEM_WORDS];
  int load_ptr;
  int pc_now;
  int acc_now;
  bit stopped_now;

  machine_report_t awaited_reports [$];
  int faults;
  int results;
  int ignored;
  int stops;

  function automatic void clear_machine();
    foreach (mem_mirror[i]) mem_mirror[i] = 0;
    load_ptr    = 0;
    pc_now      = 0;
    acc_now     = 0;
    stopped_now = 1'b0;
  endfunction

  function automatic int clip_word(int v);
    if (v > WORD_LIMIT) return WORD_LIMIT;
    if (v < -WORD_LIMIT) return -WORD_LIMIT;
    return v;
  endfunction

  // Applies one item to the mirror and returns the report it must produce
  function automatic machine_report_t run_command(logic [1:0] cmd,
                                                  logic signed [WORD_W-1:0] data);
    machine_report_t r;
    logic [2:0] st;
    logic wr, rd;
    int value, wval, word, op, addr, a, m, sum, next_pc;
    value = int'(data);
    st = ST_OK;
    wr = 1'b0;
    rd = 1'b0;
    wval = 0;
    word = 0;
    op = 0;
    addr = 0;
    case (cmd)
      CMD_CLEAR: clear_machine();
      CMD_LOAD: begin
        if (load_ptr >= MEM_WORDS) begin
          st = ST_FULL;
        end else if (value >= -WORD_LIMIT && value <= WORD_LIMIT) begin
          mem_mirror[load_ptr] = value;
          load_ptr++;
          if (load_ptr >= MEM_WORDS) st = ST_FULL;
        end
      end
      CMD_STEP: begin
        if (stopped_now || pc_now >= MEM_WORDS) begin
          st = ST_IGNORED;
        end else begin
          next_pc = pc_now + 1;
          word = mem_mirror[pc_now];
          op = word / 100;
          addr = word % 100;
          // negative words give a negative operand; only unknown opcodes see it
          a = (addr >= 0 && addr < MEM_WORDS) ? addr : 0;
          m = mem_mirror[a];
          case (op)
            OP_READ: begin
              mem_mirror[a] = clip_word(value);
              rd = 1'b1;
            end
            OP_WRITE: begin
              wr = 1'b1;
              wval = m;
            end
            OP_LOAD:  acc_now = m;
            OP_STORE: mem_mirror[a] = acc_now;
            OP_ADD, OP_SUB, OP_MUL: begin
              sum = (op == OP_ADD) ? acc_now + m :
                    (op == OP_SUB) ? acc_now - m : acc_now * m;
              if (sum > WORD_LIMIT || sum < -WORD_LIMIT) begin
                st = ST_OVF;
                next_pc = pc_now;
              end else begin
                acc_now = sum;
              end
            end
            OP_DIV: begin
              if (acc_now == 0) begin
                st = ST_DIVZ;
                next_pc = pc_now;
              end else begin
                acc_now = m / acc_now;
              end
            end
            OP_BR: next_pc = a;
            OP_BRNEG: begin
              if (acc_now < 0) next_pc = a;
            end
            OP_BRZERO: begin
              if (acc_now == 0) next_pc = a;
            end
            OP_HALT: begin
              st = ST_HALT;
              next_pc = pc_now;
            end
            default: ;
          endcase
          pc_now = next_pc;
          if (st != ST_OK) begin
            stopped_now = 1'b1;
          end else if (pc_now >= MEM_WORDS) begin
            pc_now = MEM_WORDS;
            st = ST_PAST;
            stopped_now = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.status   = st;
    r.wr_valid = wr;
    r.wr_value = wval[WORD_W-1:0];
    r.rd_taken = rd;
    r.pc       = pc_now[ADDR_W-1:0];
    r.acc      = acc_now[WORD_W-1:0];
    r.word     = word[WORD_W-1:0];
    r.op       = op[7:0];
    r.addr     = addr[7:0];
    return r;
  endfunction

  function automatic void compare_field(string name, logic signed [15:0] got,
                                        logic signed [15:0] want);
    if (got !== want) begin
      faults++;
      if (faults <= REPORT_LIMIT)
        $display("[%0t] %s differs: expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Results are checked before the item of the same edge is applied: a result
  // never belongs to an item taken at that edge
  always @(posedge clk) begin
    machine_report_t want;
    if (!rst_n) begin
      clear_machine();
      awaited_reports.delete();
    end else begin
      if (out_valid === 1'b1) begin
        results++;
        if (awaited_reports.size() == 0) begin
          faults++;
          if (faults <= REPORT_LIMIT)
            $display("[%0t] result strobe with no item outstanding", $time);
        end else begin
          want = awaited_reports.pop_front();
          compare_field("status", out_status, want.status);
          compare_field("write_valid", out_write_valid, want.wr_valid);
          compare_field("write_value", out_write_value, want.wr_value);
          compare_field("read_taken", out_read_taken, want.rd_taken);
          compare_field("program_counter", out_program_counter, want.pc);
          compare_field("acc_value", out_acc_value, want.acc);
          compare_field("instruction_word", out_instruction_word, want.word);
          compare_field("opcode", out_opcode, want.op);
          compare_field("address_field", out_address_field, want.addr);
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        want = run_command(in_cmd, in_data);
        if (want.status == ST_IGNORED) ignored++;
        if (want.status inside {ST_HALT, ST_OVF, ST_DIVZ, ST_PAST}) stops++;
        awaited_reports.push_back(want);
      end
    end
    // counters leave on the nonblocking edge so the driver reads settled values
    fault_count   <= faults;
    awaiting      <= awaited_reports.size();
    result_count  <= results;
    ignored_count <= ignored;
    stop_count    <= stops;
  end

endmodule

FILE: tb/tb_decimal_accumulator_machine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Decimal accumulator machine: testbench top
// Drives directed items and then random programs (clear, load, run) through
// the command port with sender gaps, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module tb_decimal_accumulator_machine;
  import dam_pkg::*;

  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int ITEM_TARGET  = 750;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 25;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic [1:0]               in_cmd = CMD_CLEAR;
  logic signed [WORD_W-1:0] in_data = '0;
  logic                     busy;
  logic                     out_valid;
  logic [2:0]               out_status;
  logic                     out_write_valid;
  logic signed [WORD_W-1:0] out_write_value;
  logic                     out_read_taken;
  logic [ADDR_W-1:0]        out_program_counter;
  logic signed [WORD_W-1:0] out_acc_value;
  logic signed [WORD_W-1:0] out_instruction_word;
  logic signed [7:0]        out_opcode;
  logic signed [7:0]        out_address_field;

  int fault_count;
  int awaiting;
  int result_count;
  int ignored_count;
  int stop_count;

  int sent_count = 0;
  int idle_pct = 24;
  int run_count = 0;
  int fill_count = 0;

  decimal_accumulator_machine u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_cmd               (in_cmd),
    .in_data              (in_data),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_write_valid      (out_write_valid),
    .out_write_value      (out_write_value),
    .out_read_taken       (out_read_taken),
    .out_program_counter  (out_program_counter),
    .out_acc_value        (out_acc_value),
    .out_instruction_word (out_instruction_word),
    .out_opcode           (out_opcode),
    .out_address_field    (out_address_field)
  );

  dam_result_checker u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_cmd               (in_cmd),
    .in_data              (in_data),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_write_valid      (out_write_valid),
    .out_write_value      (out_write_value),
    .out_read_taken       (out_read_taken),
    .out_program_counter  (out_program_counter),
    .out_acc_value        (out_acc_value),
    .out_instruction_word (out_instruction_word),
    .out_opcode           (out_opcode),
    .out_address_field    (out_address_field),
    .fault_count          (fault_count),
    .awaiting             (awaiting),
    .result_count         (result_count),
    .ignored_count        (ignored_count),
    .stop_count           (stop_count)
  );

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Run timed out after %0d cycles", LIMIT_CYCLES);
    $display("** decimal_accumulator_machine: FAILED **");
    $finish;
  end

  function automatic logic signed [WORD_W-1:0] instr(logic signed [7:0] op, int operand);
    return WORD_W'(int'(op) * 100 + operand);
  endfunction

  // In-range word, biased towards the extremes and small values
  function automatic logic signed [WORD_W-1:0] data_word();
    case ($urandom_range(0, 4))
      0: return 15'sd9999;
      1: return -15'sd9999;
      2: return WORD_W'($urandom_range(0, 200) - 100);
      default: return WORD_W'($urandom_range(0, 19998) - 9999);
    endcase
  endfunction

  // Value for a read step: sometimes any 15-bit pattern, so saturation is hit
  function automatic logic signed [WORD_W-1:0] pick_value();
    if ($urandom_range(0, 4) == 0) return WORD_W'($urandom);
    return data_word();
  endfunction

  function automatic logic signed [WORD_W-1:0] out_of_range_value();
    if ($urandom_range(0, 1) == 0) return WORD_W'($urandom_range(10000, 16383));
    return WORD_W'(32'd0 - $urandom_range(10000, 16384));
  endfunction

  function automatic logic signed [7:0] pick_opcode();
    case ($urandom_range(0, 11))
      0:  return OP_READ;
      1:  return OP_WRITE;
      2:  return OP_LOAD;
      3:  return OP_STORE;
      4:  return OP_ADD;
      5:  return OP_SUB;
      6:  return OP_DIV;
      7:  return OP_MUL;
      8:  return OP_BR;
      9:  return OP_BRNEG;
      10: return OP_BRZERO;
      default: return OP_HALT;
    endcase
  endfunction

  // Program word: branches aim into the code (now and then near the end of
  // memory), data operations into the words just past the code
  function automatic logic signed [WORD_W-1:0] program_word(int code_len);
    logic signed [7:0] op;
    int target;
    if ($urandom_range(0, 99) >= 88) begin
      case ($urandom_range(0, 3))
        0: return WORD_W'($urandom_range(0, 9999));
        1: return WORD_W'(32'd0 - $urandom_range(1, 9999));
        2: return 15'sd9999;
        default: return -15'sd9999;
      endcase
    end
    op = pick_opcode();
    if (op == OP_BR || op == OP_BRNEG || op == OP_BRZERO)
      target = ($urandom_range(0, 9) == 0) ? $urandom_range(90, 99) :
               $urandom_range(0, code_len - 1);
    else
      target = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) :
               $urandom_range(code_len, code_len + 7);
    return instr(op, target);
  endfunction

  // One item: random sender gap, then hold until taken
  task automatic send_item(input logic [1:0] cmd, input logic signed [WORD_W-1:0] data);
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start   <= 1'b0;
      in_cmd  <= 2'($urandom);
      in_data <= WORD_W'($urandom);
      @(posedge clk);
    end
    start   <= 1'b1;
    in_cmd  <= cmd;
    in_data <= data;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sent_count++;
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
  endtask

  // Clear, load a program and its data, then step through it
  task automatic run_program(input bit fill);
    int code_len;
    int i;
    run_count++;
    if (fill) fill_count++;
    send_item(CMD_CLEAR, WORD_W'($urandom));
    code_len = fill ? MEM_WORDS : $urandom_range(3, 24);
    for (i = 0; i < code_len; i++) begin
      if ($urandom_range(0, 19) == 0) send_item(CMD_LOAD, out_of_range_value());
      send_item(CMD_LOAD, program_word(fill ? 92 : code_len));
    end
    // a full memory refuses the extra loads
    if (fill) repeat ($urandom_range(1, 3)) send_item(CMD_LOAD, data_word());
    else repeat ($urandom_range(0, 8)) send_item(CMD_LOAD, data_word());
    repeat ($urandom_range(4, 40)) begin
      case ($urandom_range(0, 29))
        0: send_item(CMD_SPARE, WORD_W'($urandom));
        1: send_item(CMD_LOAD, data_word());
        default: ;
      endcase
      send_item(CMD_STEP, pick_value());
    end
  endtask

  // Stimulus
  initial begin
    int done_items;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // spare command, step on empty memory, refused loads
    send_item(CMD_SPARE, -15'sd1);
    send_item(CMD_STEP, 15'sd0);
    send_item(CMD_CLEAR, 15'sd0);
    send_item(CMD_LOAD, 15'sh3FFF);
    send_item(CMD_LOAD, 15'sh4000);

    // each data operation and both conditional branches, ending in a divide by zero
    send_item(CMD_LOAD, instr(OP_READ, 20));
    send_item(CMD_LOAD, instr(OP_WRITE, 20));
    send_item(CMD_LOAD, instr(OP_LOAD, 20));
    send_item(CMD_LOAD, instr(OP_DIV, 20));
    send_item(CMD_LOAD, instr(OP_READ, 21));
    send_item(CMD_LOAD, instr(OP_ADD, 21));
    send_item(CMD_LOAD, instr(OP_BRNEG, 7));
    send_item(CMD_LOAD, instr(OP_STORE, 22));
    send_item(CMD_LOAD, instr(OP_SUB, 22));
    send_item(CMD_LOAD, instr(OP_BRZERO, 10));
    send_item(CMD_LOAD, instr(OP_MUL, 20));
    send_item(CMD_LOAD, instr(OP_DIV, 20));
    send_item(CMD_STEP, 15'sh3FFF);    // read saturates high
    send_item(CMD_STEP, pick_value());
    send_item(CMD_STEP, pick_value());
    send_item(CMD_STEP, pick_value());
    send_item(CMD_STEP, 15'sh4000);    // read saturates low
    repeat (8) send_item(CMD_STEP, pick_value());   // last one hits a stopped machine

    // running past the last word
    send_item(CMD_CLEAR, 15'sd0);
    send_item(CMD_LOAD, instr(OP_BR, 99));
    repeat (3) send_item(CMD_STEP, 15'sd0);

    // halt
    send_item(CMD_CLEAR, 15'sd0);
    send_item(CMD_LOAD, instr(OP_HALT, 0));
    send_item(CMD_STEP, 15'sd0);

    // overflow keeps the accumulator
    send_item(CMD_CLEAR, 15'sd0);
    send_item(CMD_LOAD, instr(OP_LOAD, 2));
    send_item(CMD_LOAD, instr(OP_ADD, 2));
    send_item(CMD_LOAD, 15'sd9999);
    send_item(CMD_STEP, 15'sd0);
    send_item(CMD_STEP, 15'sd0);
    wait_for_results();

    // random programs; sender gaps change with progress
    run_program(1'b1);
    done_items = sent_count;
    while (done_items < ITEM_TARGET) begin
      idle_pct = (done_items < ITEM_TARGET / 3) ? 24 :
                 (done_items < 2 * ITEM_TARGET / 3) ? 67 : 0;
      if ($urandom_range(0, 5) == 0) wait_for_results();
      run_program($urandom_range(0, 11) == 0);
      done_items = sent_count;
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d items in %0d programs (%0d filling all memory), %0d results",
             sent_count, run_count, fill_count, result_count);
    $display("Machine stopped %0d times; %0d steps fell on a stopped machine",
             stop_count, ignored_count);
    if (fault_count == 0 && awaiting == 0)
      $display("** decimal_accumulator_machine: PASSED **");
    else
      $display("** decimal_accumulator_machine: FAILED **");
    $finish;
  end

endmodule
